// File: hdl/tcrt_pkg.sv
// Package for the three-channel root timer: operation codes, mode bits, shared types.
package tcrt_pkg;

  localparam int unsigned NumCountersDef = 3;
  localparam int unsigned DataW          = 16;
  localparam int unsigned IrqW           = 3;
  localparam logic [15:0] HsyncDivReset  = 16'd2146;

  // Mode register bits
  localparam int unsigned ModeStopBit     = 0;
  localparam int unsigned ModeResetTgtBit = 3;
  localparam int unsigned ModeIrqTgtBit   = 4;
  localparam int unsigned ModeIrqOvfBit   = 5;
  localparam int unsigned ModeRepeatBit   = 6;
  localparam int unsigned ModeClkABit     = 8;
  localparam int unsigned ModeClkBBit     = 9;

  localparam logic [15:0] ModeRequest  = 16'h0400;
  localparam logic [15:0] ModeHitTgt   = 16'h0800;
  localparam logic [15:0] ModeHitOvf   = 16'h1000;
  localparam logic [15:0] ModeReadKeep = 16'he7ff;
  localparam logic [15:0] CountTop     = 16'hffff;

  // Register map
  localparam logic RegHsyncDiv = 1'b0;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_WR_COUNT  = 3'd1,
    OP_WR_MODE   = 3'd2,
    OP_WR_TARGET = 3'd3,
    OP_RD_COUNT  = 3'd4,
    OP_RD_MODE   = 3'd5,
    OP_RD_TARGET = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  // Per-channel command for the processing cycle
  typedef struct packed {
    logic tick;
    logic wr_count;
    logic wr_mode;
    logic wr_target;
    logic rd_mode;
  } chan_cmd_t;

endpackage

// File: hdl/tcrt_regs.sv
// APB-style configuration register holding the hsync divider.
module tcrt_regs
  import tcrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] hsync_div_o
);

  logic [15:0] hsync_div_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegHsyncDiv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsync_div_q <= HsyncDivReset;
    end else if (wr_en) begin
      hsync_div_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegHsyncDiv) begin
      prdata = {16'd0, hsync_div_q};
    end
  end

  assign hsync_div_o = hsync_div_q;

endmodule

// File: hdl/tcrt_chan.sv
// One timer channel: count, mode, target, prescaler and interrupt latch.
module tcrt_chan
  import tcrt_pkg::*;
#(
  parameter int unsigned CHAN = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        exec_i,
  input  chan_cmd_t   cmd_i,
  input  logic [15:0] wdata_i,
  input  logic [15:0] hsync_div_i,
  output logic [15:0] count_o,
  output logic [15:0] mode_o,
  output logic [15:0] target_o,
  output logic        irq_o
);

  logic [15:0] count_q, count_d;
  logic [15:0] phase_q, phase_d;
  logic [15:0] mode_q, mode_d;
  logic [15:0] target_q, target_d;
  logic        fired_q, fired_d;

  logic [15:0] rate;
  logic        stopped;
  logic [16:0] phase_inc;
  logic [15:0] count_inc;
  logic        ev_tgt, ev_ovf, ev_any, enable, pulse;

  // Prescaler divide ratio for this channel
  always_comb begin
    rate    = 16'd1;
    stopped = 1'b0;
    if (CHAN == 0) begin
      if (mode_q[ModeClkABit]) rate = 16'd5;
    end else if (CHAN == 1) begin
      if (mode_q[ModeClkABit]) rate = (hsync_div_i == 16'd0) ? 16'd1 : hsync_div_i;
    end else if (CHAN == 2) begin
      stopped = mode_q[ModeStopBit];
      if (mode_q[ModeClkBBit]) rate = 16'd8;
    end
  end

  assign phase_inc = {1'b0, phase_q} + 17'd1;
  assign count_inc = count_q + 16'd1;

  always_comb begin
    count_d  = count_q;
    phase_d  = phase_q;
    mode_d   = mode_q;
    target_d = target_q;
    fired_d  = fired_q;
    ev_tgt   = 1'b0;
    ev_ovf   = 1'b0;
    if (exec_i && cmd_i.tick && !stopped) begin
      if (count_q == CountTop) begin
        ev_ovf  = 1'b1;
        count_d = '0;
      end else if (phase_inc < {1'b0, rate}) begin
        phase_d = phase_inc[15:0];
      end else begin
        phase_d = '0;
        if (count_inc == target_q) begin
          ev_tgt  = 1'b1;
          count_d = mode_q[ModeResetTgtBit] ? 16'd0 : count_inc;
        end else if (count_inc == CountTop) begin
          ev_ovf  = 1'b1;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
    end
    ev_any = ev_tgt || ev_ovf;
    enable = ev_tgt ? mode_q[ModeIrqTgtBit] : mode_q[ModeIrqOvfBit];
    pulse  = ev_any && enable && (mode_q[ModeRepeatBit] || !fired_q);
    if (ev_any) begin
      mode_d = mode_q | ModeRequest | (ev_tgt ? ModeHitTgt : ModeHitOvf);
    end
    if (pulse) fired_d = 1'b1;

    // Bus accesses (never in the same transaction as a tick)
    if (exec_i) begin
      if (cmd_i.wr_count) begin
        count_d = wdata_i;
        phase_d = '0;
      end
      if (cmd_i.wr_mode) begin
        mode_d  = wdata_i;
        fired_d = 1'b0;
        count_d = '0;
        phase_d = '0;
      end
      if (cmd_i.wr_target) begin
        target_d = wdata_i;
        phase_d  = '0;
      end
      if (cmd_i.rd_mode) begin
        mode_d = mode_q & ModeReadKeep;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      phase_q  <= '0;
      mode_q   <= '0;
      target_q <= '0;
      fired_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      phase_q  <= phase_d;
      mode_q   <= mode_d;
      target_q <= target_d;
      fired_q  <= fired_d;
    end
  end

  assign count_o  = count_q;
  assign mode_o   = mode_q;
  assign target_o = target_q;
  assign irq_o    = pulse;

endmodule

// File: hdl/three_channel_root_timer_core.sv
// Top level of the three-channel root timer: input register, channels, result register.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   operation_i (tick, count/mode/target write, count/mode/target read),
//   counter_index_i and write_data_i. Each tick stands for one system clock.
//   Output channel (out_valid_o / out_stall_i) returns exactly one transaction
//   per input item: read_data_o (read value, else zero) and irq_pulses_o
//   (bit n set when counter n pulsed its interrupt on that tick).
//   The input register holds the item; the channel update then writes the
//   result register. Throughput: one item per cycle while out_stall_i is low;
//   all channel work for an item is a single pass of the counter/prescaler
//   logic between the two registers.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_stall_o rises until the result drains.
//   Reset (rst_ni low, asynchronous) clears all counts, modes, targets,
//   prescalers and interrupt latches, and empties both registers; the hsync
//   divider returns to 2146.
//   The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the
//   hsync divider at address 0; write it only while the block is idle.
module three_channel_root_timer_core
  import tcrt_pkg::*;
#(
  parameter int unsigned NUM_COUNTERS = NumCountersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [1:0]  counter_index_i,
  input  logic [15:0] write_data_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic [2:0]  irq_pulses_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Input register
  logic        item_valid_q, item_valid_d;
  logic [2:0]  op_q;
  logic [1:0]  idx_q;
  logic [15:0] data_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [15:0] rdata_q, rdata_d;
  logic [2:0]  irq_q, irq_d;

  logic        out_free, advance, accept;
  logic        idx_ok;
  op_e         op;
  logic [15:0] hsync_div;

  logic [15:0] cnt_w [NUM_COUNTERS];
  logic [15:0] mode_w [NUM_COUNTERS];
  logic [15:0] tgt_w [NUM_COUNTERS];
  logic        irq_w [NUM_COUNTERS];
  chan_cmd_t   cmd_w [NUM_COUNTERS];

  // Handshake: result register frees when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (advance) begin
      item_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      idx_q  <= counter_index_i;
      data_q <= write_data_i;
    end
    if (advance) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign op     = op_e'(op_q);
  assign idx_ok = 32'(idx_q) < NUM_COUNTERS;

  // Per-channel command decode
  always_comb begin
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      cmd_w[k] = '0;
      cmd_w[k].tick = (op == OP_TICK);
      if (32'(idx_q) == k) begin
        cmd_w[k].wr_count  = (op == OP_WR_COUNT);
        cmd_w[k].wr_mode   = (op == OP_WR_MODE);
        cmd_w[k].wr_target = (op == OP_WR_TARGET);
        cmd_w[k].rd_mode   = (op == OP_RD_MODE);
      end
    end
  end

  tcrt_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .hsync_div_o (hsync_div)
  );

  for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_chan
    tcrt_chan #(
      .CHAN (g)
    ) u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .exec_i      (advance),
      .cmd_i       (cmd_w[g]),
      .wdata_i     (data_q),
      .hsync_div_i (hsync_div),
      .count_o     (cnt_w[g]),
      .mode_o      (mode_w[g]),
      .target_o    (tgt_w[g]),
      .irq_o       (irq_w[g])
    );
  end

  // Result: read mux uses pre-update state; interrupt bits only for counters 0..2
  always_comb begin
    rdata_d = '0;
    irq_d   = '0;
    for (int k = 0; k < NUM_COUNTERS; k++) begin
      if (idx_ok && (32'(idx_q) == k)) begin
        case (op)
          OP_RD_COUNT:  rdata_d = cnt_w[k];
          OP_RD_MODE:   rdata_d = mode_w[k];
          OP_RD_TARGET: rdata_d = tgt_w[k];
          default:      rdata_d = rdata_d;
        endcase
      end
      if (k < IrqW) begin
        irq_d[k[1:0]] = irq_w[k];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = rdata_q;
  assign irq_pulses_o = irq_q;

endmodule
